// File: rtl/alt_pkg.sv
package alt_pkg;

	// Fixed field widths of the item and result beats, the entry age and the age limit.
	localparam int KEY_W = 64;
	localparam int AGE_W = 5;
	localparam int CNT_W = 9;
	localparam int LIM_W = 4;

	// Default table depth and register reset value.
	localparam int DEPTH_DEF = 256;
	localparam logic [LIM_W-1:0] LIM_RESET = 4'd10;

	// An age stops counting here.
	localparam logic [AGE_W-1:0] AGE_MAX = 5'd31;

	// Configuration port geometry.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register indexes, taken from the word index bit of paddr.
	localparam logic REG_AGE_LIMIT = 1'b0;

	// Item commands.
	localparam logic CMD_ANNOUNCE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_REFRESHED = 2'd0,
		STAT_ADDED = 2'd1,
		STAT_DROPPED = 2'd2,
		STAT_TICK = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Control of the cell row for one cycle.
	typedef struct packed {
		logic shift;
		logic load;
	} chain_ctl_t;

	typedef struct packed {
		logic command;
		logic [KEY_W-1:0] key;
	} item_t;

	typedef struct packed {
		status_t status;
		logic [CNT_W-1:0] entry_count;
		logic [CNT_W-1:0] removed_count;
		logic changed;
	} result_t;

endpackage

// File: rtl/aging_learning_table_top.sv
// Learning table with aging. Keys live in a row of DEPTH cells in order of
// arrival. Every item walks the held entries once: each cycle the entry at the
// head is examined and rotated back in behind the others, a pace set by the
// single head comparator and the one-entry shift of the cell row. An announce
// refreshes a matching key or appends it at the end, and is dropped when the
// table is full; a tick ages every entry and squeezes out the expired ones
// while the order is kept. A new item is taken once the previous result is
// registered, even if that result beat is still stalled. The age limit register
// sits at byte address 0; the user must write it only while the block is idle,
// as the block itself does not enforce this.
module aging_learning_table_top #(
	parameter int DEPTH = alt_pkg::DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input alt_pkg::item_t item,
	output logic result_valid,
	input logic result_stall,
	output alt_pkg::result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [alt_pkg::PADDR_W-1:0] paddr,
	input logic [alt_pkg::PDATA_W-1:0] pwdata,
	output logic [alt_pkg::PDATA_W-1:0] prdata,
	output logic pready
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	alt_pkg::state_t state_q, state_d;
	logic [alt_pkg::LIM_W-1:0] lim_q, lim_eff;
	logic [CW-1:0] held_q, scan_n_q, step_q, live_q, live_m1, removed;
	logic hit_q, added_q, cmd_q;
	logic [alt_pkg::KEY_W-1:0] key_q;
	alt_pkg::result_t result_q, result_d;
	logic result_valid_q;

	alt_pkg::chain_ctl_t ctl;
	logic [IW-1:0] wr_idx;
	logic [alt_pkg::KEY_W-1:0] wr_key, head_key;
	logic [alt_pkg::AGE_W-1:0] wr_age, head_age, head_age_inc, head_age_new;
	logic item_take, scan_step, done_load, out_free, head_match, keep, append;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[alt_pkg::PADDR_W-1] == alt_pkg::REG_AGE_LIMIT) ?
		alt_pkg::PDATA_W'(lim_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= alt_pkg::LIM_RESET;
		end else if (psel && penable && pwrite
			&& paddr[alt_pkg::PADDR_W-1] == alt_pkg::REG_AGE_LIMIT) begin
			lim_q <= pwdata[alt_pkg::LIM_W-1:0];
		end
	end

	// A limit of zero behaves as one.
	assign lim_eff = (lim_q == '0) ? alt_pkg::LIM_W'(1) : lim_q;

	// Head entry processing.
	assign head_match = (head_key == key_q);
	assign head_age_inc = (head_age < alt_pkg::AGE_MAX) ? head_age + 1'b1 : head_age;
	assign keep = (cmd_q == alt_pkg::CMD_ANNOUNCE)
		|| (head_age_inc <= alt_pkg::AGE_W'(lim_eff));
	assign head_age_new = (cmd_q == alt_pkg::CMD_TICK) ? head_age_inc :
		(head_match ? '0 : head_age);

	assign item_take = item_valid && !item_stall;
	assign scan_step = (state_q == alt_pkg::ST_SCAN) && (step_q != scan_n_q);
	assign out_free = !result_valid_q || !result_stall;
	assign append = (cmd_q == alt_pkg::CMD_ANNOUNCE) && !hit_q && (held_q < CW'(DEPTH));
	assign live_m1 = live_q - 1'b1;
	assign removed = scan_n_q - live_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			alt_pkg::ST_IDLE: begin
				if (item_take) state_d = alt_pkg::ST_SCAN;
			end
			alt_pkg::ST_SCAN: begin
				if (!scan_step) state_d = alt_pkg::ST_DONE;
			end
			alt_pkg::ST_DONE: begin
				if (out_free) state_d = alt_pkg::ST_IDLE;
			end
			default: state_d = alt_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, cell row control and the result.
	always_comb begin
		item_stall = (state_q != alt_pkg::ST_IDLE);
		done_load = (state_q == alt_pkg::ST_DONE) && out_free;
		ctl.shift = scan_step;
		ctl.load = (scan_step && keep) || (done_load && append);
		wr_idx = scan_step ? live_m1[IW-1:0] : held_q[IW-1:0];
		wr_key = scan_step ? head_key : key_q;
		wr_age = scan_step ? head_age_new : '0;
		result_d = '0;
		if (cmd_q == alt_pkg::CMD_TICK) begin
			result_d.status = alt_pkg::STAT_TICK;
			result_d.entry_count = alt_pkg::CNT_W'(live_q);
			result_d.removed_count = alt_pkg::CNT_W'(removed);
			result_d.changed = (removed != '0) || added_q;
		end else if (hit_q) begin
			result_d.status = alt_pkg::STAT_REFRESHED;
			result_d.entry_count = alt_pkg::CNT_W'(held_q);
		end else if (append) begin
			result_d.status = alt_pkg::STAT_ADDED;
			result_d.entry_count = alt_pkg::CNT_W'(held_q + 1'b1);
		end else begin
			result_d.status = alt_pkg::STAT_DROPPED;
			result_d.entry_count = alt_pkg::CNT_W'(held_q);
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alt_pkg::ST_IDLE;
			held_q <= '0;
			added_q <= 1'b0;
			scan_n_q <= '0;
			step_q <= '0;
			live_q <= '0;
			hit_q <= 1'b0;
			cmd_q <= alt_pkg::CMD_ANNOUNCE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_take) begin
				cmd_q <= item.command;
				scan_n_q <= held_q;
				live_q <= held_q;
				step_q <= '0;
				hit_q <= 1'b0;
			end else if (scan_step) begin
				step_q <= step_q + 1'b1;
				if (!keep) live_q <= live_m1;
				if (cmd_q == alt_pkg::CMD_ANNOUNCE && head_match) hit_q <= 1'b1;
			end
			if (done_load) begin
				if (cmd_q == alt_pkg::CMD_TICK) begin
					held_q <= live_q;
					added_q <= 1'b0;
				end else if (append) begin
					held_q <= held_q + 1'b1;
					added_q <= 1'b1;
				end
			end
			if (done_load) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (item_take) key_q <= item.key;
		if (done_load) result_q <= result_d;
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	alt_chain #(.DEPTH(DEPTH)) u_chain (
		.clk(clk),
		.ctl(ctl),
		.wr_idx(wr_idx),
		.wr_key(wr_key),
		.wr_age(wr_age),
		.head_key(head_key),
		.head_age(head_age)
	);

	// The walk never runs past the entries held at the start.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == alt_pkg::ST_SCAN |-> step_q <= scan_n_q && live_q <= scan_n_q)
		else $error("scan counters out of range");

	// The table never holds more than its depth.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(DEPTH))
		else $error("held count exceeds depth");

	// A result beat appears only when an item finishes.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == alt_pkg::ST_DONE)
		else $error("result beat without a finished item");

	// Announces never shrink the list.
	a_announce_keep: assert property (@(posedge clk) disable iff (!arst_n)
		scan_step && cmd_q == alt_pkg::CMD_ANNOUNCE |=> live_q == $past(live_q))
		else $error("announce dropped an entry");

endmodule

// File: rtl/alt_cell.sv
module alt_cell #(
	parameter int IDX_W = 8,
	parameter int IDX = 0
) (
	input logic clk,
	input alt_pkg::chain_ctl_t ctl,
	input logic [IDX_W-1:0] wr_idx,
	input logic [alt_pkg::KEY_W-1:0] wr_key,
	input logic [alt_pkg::AGE_W-1:0] wr_age,
	input logic [alt_pkg::KEY_W-1:0] nbr_key,
	input logic [alt_pkg::AGE_W-1:0] nbr_age,
	output logic [alt_pkg::KEY_W-1:0] key,
	output logic [alt_pkg::AGE_W-1:0] age
);

	logic [alt_pkg::KEY_W-1:0] key_q;
	logic [alt_pkg::AGE_W-1:0] age_q;
	logic hit_idx;

	assign hit_idx = (wr_idx == IDX_W'(IDX));

	// A directed write wins; otherwise the cell takes its upper neighbor on a shift.
	always_ff @(posedge clk) begin
		if (ctl.load && hit_idx) begin
			key_q <= wr_key;
			age_q <= wr_age;
		end else if (ctl.shift) begin
			key_q <= nbr_key;
			age_q <= nbr_age;
		end
	end

	assign key = key_q;
	assign age = age_q;

endmodule

// File: rtl/alt_chain.sv
module alt_chain #(
	parameter int DEPTH = alt_pkg::DEPTH_DEF
) (
	input logic clk,
	input alt_pkg::chain_ctl_t ctl,
	input logic [$clog2(DEPTH)-1:0] wr_idx,
	input logic [alt_pkg::KEY_W-1:0] wr_key,
	input logic [alt_pkg::AGE_W-1:0] wr_age,
	output logic [alt_pkg::KEY_W-1:0] head_key,
	output logic [alt_pkg::AGE_W-1:0] head_age
);

	localparam int IDX_W = $clog2(DEPTH);

	logic [alt_pkg::KEY_W-1:0] key_w [DEPTH];
	logic [alt_pkg::AGE_W-1:0] age_w [DEPTH];

	// Row of cells; each shifts toward the head, the last one holds its own value.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_last
			alt_cell #(.IDX_W(IDX_W), .IDX(i)) u_cell (
				.clk(clk), .ctl(ctl), .wr_idx(wr_idx), .wr_key(wr_key), .wr_age(wr_age),
				.nbr_key(key_w[i]), .nbr_age(age_w[i]),
				.key(key_w[i]), .age(age_w[i])
			);
		end else begin : g_mid
			alt_cell #(.IDX_W(IDX_W), .IDX(i)) u_cell (
				.clk(clk), .ctl(ctl), .wr_idx(wr_idx), .wr_key(wr_key), .wr_age(wr_age),
				.nbr_key(key_w[i+1]), .nbr_age(age_w[i+1]),
				.key(key_w[i]), .age(age_w[i])
			);
		end
	end

	assign head_key = key_w[0];
	assign head_age = age_w[0];

endmodule
